### rtl/tfq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfq_pkg
// Shared constants and types for the tilt/flip orientation qualifier.
// ----------------------------------------------------------------------------
package tfq_pkg;

  localparam int HISTORY_DEPTH = 28;
  localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
  localparam int CNT_W         = $clog2(HISTORY_DEPTH);

  localparam int ACC_W     = 16;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MANUAL_ORIENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP_LEVEL    = 2'd2;

  localparam logic [CFG_W-1:0] TILT_LIMIT_RST = 15'd819;
  localparam logic [CFG_W-1:0] FLIP_LEVEL_RST = 15'd3277;

  localparam logic [HIST_AW-1:0] LAST_SLOT = HIST_AW'(HISTORY_DEPTH - 1);
  localparam logic [CNT_W-1:0]   LAST_CNT  = CNT_W'(HISTORY_DEPTH - 1);
  localparam logic [CNT_W-1:0]   HALF_CNT  = CNT_W'(HISTORY_DEPTH / 2);

  typedef struct packed {
    logic               wr_en;
    logic [HIST_AW-1:0] wr_addr;
    logic               wr_data;
    logic               rd_en;
    logic [HIST_AW-1:0] rd_addr;
    logic               clr;
  } hist_req_t;

  function automatic logic [HIST_AW-1:0] next_slot(input logic [HIST_AW-1:0] a);
    return (a == LAST_SLOT) ? '0 : a + HIST_AW'(1);
  endfunction

endpackage
`default_nettype wire

### rtl/tfq_hist.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfq_hist
// History ring storage: one-bit synchronous memory with registered read and
// per-entry valid bits; an entry that is not valid reads as zero.
// ----------------------------------------------------------------------------
module tfq_hist
  import tfq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire hist_req_t req,
  output logic           rd_data
);

  logic                     mem_r [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] vld_r;
  logic                     rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
  end

  // Clear drops every entry at once.
  always_ff @(posedge clk) begin
    if (!rst_n || req.clr) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem_r[req.rd_addr] & vld_r[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

### rtl/tilt_flip_qualifier.sv
`default_nettype none
// A manual-mode tick or the first (priming) tick goes straight to its result;
// a normal tick first walks the history memory, one read per cycle, to decide.
// One tick at a time: no new tick is taken until the last one's result has been
// committed to the output register, which waits while the output is stalled.
// Reset (synchronous, active low): registers to their defaults, history
// entries invalid (read as zero), orientation up, not primed.
// ----------------------------------------------------------------------------
// tilt_flip_qualifier
// Marks upside-down samples into a history ring and toggles the screen
// orientation once the mark has been seen steadily.
// ----------------------------------------------------------------------------
module tilt_flip_qualifier
  import tfq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic signed [ACC_W-1:0] in_accel_x,
  input  wire logic signed [ACC_W-1:0] in_accel_y,
  input  wire logic signed [ACC_W-1:0] in_accel_z,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_orientation,
  output logic                       out_redraw_request
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_LAST = 3'd2;
  localparam logic [2:0] ST_DEC  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  // Configuration registers
  logic             manual_r;
  logic [CFG_W-1:0] tilt_r;
  logic [CFG_W-1:0] flip_r;

  // Control and scan state
  logic [2:0]         state_r, state_nxt;
  logic [HIST_AW-1:0] wp_r, wp_nxt;
  logic               primed_r, primed_nxt;
  logic               dir_r, dir_nxt;
  logic [HIST_AW-1:0] ra_r, ra_nxt;
  logic [CNT_W-1:0]   iss_r, iss_nxt;
  logic               ret_vld_r;
  logic [CNT_W-1:0]   ret_idx_r;
  logic [CNT_W-1:0]   marks_r, marks_nxt;
  logic [CNT_W-1:0]   trans_r, trans_nxt;
  logic               prev_r, prev_nxt;
  logic               tgl_r, tgl_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_dir_r, out_dir_nxt;
  logic               out_redraw_r, out_redraw_nxt;

  hist_req_t hreq;
  logic      hist_bit;

  logic               accept;
  logic               commit;
  logic               mark;
  logic signed [ACC_W:0] ax, ay, az, mag_x, mag_z, tilt_s, flip_s;

  // Hold configuration; ignore indexes beyond the register list.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      manual_r <= 1'b0;
      tilt_r   <= TILT_LIMIT_RST;
      flip_r   <= FLIP_LEVEL_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MANUAL_ORIENT: manual_r <= cfg_data[0];
        REG_TILT_LIMIT:    tilt_r   <= cfg_data;
        REG_FLIP_LEVEL:    flip_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Upside-down test on the incoming sample; 17-bit signed so |-32768| fits.
  always_comb begin
    ax     = {in_accel_x[ACC_W-1], in_accel_x};
    ay     = {in_accel_y[ACC_W-1], in_accel_y};
    az     = {in_accel_z[ACC_W-1], in_accel_z};
    mag_x  = ax[ACC_W] ? -ax : ax;
    mag_z  = az[ACC_W] ? -az : az;
    tilt_s = signed'({2'b00, tilt_r});
    flip_s = signed'({2'b00, flip_r});
    if (mag_x > tilt_s || mag_z > tilt_s) begin
      mark = 1'b0;
    end else if (!dir_r) begin
      mark = ay > flip_s;
    end else begin
      mark = ay < -flip_s;
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  // Deliver only once the output register is free or being emptied.
  assign commit   = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  // History memory requests: write the mark on a primed, non-manual transfer,
  // walk during scan, drop all entries when the orientation toggles.
  always_comb begin
    hreq         = '0;
    hreq.wr_en   = accept && !manual_r && primed_r;
    hreq.wr_addr = wp_r;
    hreq.wr_data = mark;
    hreq.rd_en   = (state_r == ST_SCAN);
    hreq.rd_addr = ra_r;
    hreq.clr     = commit && tgl_r;
  end

  tfq_hist u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (hreq),
    .rd_data (hist_bit)
  );

  always_comb begin
    state_nxt      = state_r;
    wp_nxt         = wp_r;
    primed_nxt     = primed_r;
    dir_nxt        = dir_r;
    ra_nxt         = ra_r;
    iss_nxt        = iss_r;
    marks_nxt      = marks_r;
    trans_nxt      = trans_r;
    prev_nxt       = prev_r;
    tgl_nxt        = tgl_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_dir_nxt    = out_dir_r;
    out_redraw_nxt = out_redraw_r;

    // Accumulate returning history bits: marks over all but the newest
    // entry, transitions over every adjacent pair.
    if (ret_vld_r) begin
      if (ret_idx_r != LAST_CNT) begin
        marks_nxt = marks_r + CNT_W'(hist_bit);
      end
      if (ret_idx_r != '0) begin
        trans_nxt = trans_r + CNT_W'(hist_bit ^ prev_r);
      end
      prev_nxt = hist_bit;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          marks_nxt = '0;
          trans_nxt = '0;
          if (manual_r) begin
            tgl_nxt   = 1'b0;
            state_nxt = ST_FIN;
          end else if (!primed_r) begin
            // A primed ring is uniform: a full ring of marks always
            // qualifies, a ring of clear entries matches the reset state.
            primed_nxt = 1'b1;
            wp_nxt     = '0;
            tgl_nxt    = mark;
            state_nxt  = ST_FIN;
          end else begin
            wp_nxt    = next_slot(wp_r);
            ra_nxt    = next_slot(wp_r);
            iss_nxt   = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        ra_nxt  = next_slot(ra_r);
        iss_nxt = iss_r + CNT_W'(1);
        if (iss_r == LAST_CNT) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        state_nxt = ST_DEC;
      end
      ST_DEC: begin
        tgl_nxt   = (marks_r > HALF_CNT) && (trans_r < (marks_r >> 1));
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (commit) begin
          dir_nxt        = dir_r ^ tgl_r;
          out_valid_nxt  = 1'b1;
          out_dir_nxt    = dir_r ^ tgl_r;
          out_redraw_nxt = tgl_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      primed_r    <= 1'b0;
      dir_r       <= 1'b0;
      ret_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      iss_r       <= '0;
      marks_r     <= '0;
      trans_r     <= '0;
      tgl_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      primed_r    <= primed_nxt;
      dir_r       <= dir_nxt;
      ret_vld_r   <= (state_r == ST_SCAN);
      out_valid_r <= out_valid_nxt;
      iss_r       <= iss_nxt;
      marks_r     <= marks_nxt;
      trans_r     <= trans_nxt;
      tgl_r       <= tgl_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ra_r         <= ra_nxt;
    ret_idx_r    <= iss_r;
    prev_r       <= prev_nxt;
    out_dir_r    <= out_dir_nxt;
    out_redraw_r <= out_redraw_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_orientation    = out_dir_r;
  assign out_redraw_request = out_redraw_r;

  // A committed toggle must flip the held orientation.
  a_toggle_flips: assert property (@(posedge clk) disable iff (!rst_n)
    commit && tgl_r |=> dir_r != $past(dir_r))
    else $error("toggle did not flip orientation");

  // Read data only returns while the walk is in flight.
  a_ret_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ret_vld_r |-> (state_r == ST_SCAN || state_r == ST_LAST))
    else $error("history read returned outside scan");

  // Counters stay within the ring.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    marks_r <= LAST_CNT && trans_r <= LAST_CNT && wp_r <= LAST_SLOT)
    else $error("scan counter out of range");

  // No new transfer while a tick is still being worked on.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("input taken during active tick");

endmodule
`default_nettype wire

### bench/tb.sv
// ----------------------------------------------------------------------------
// tilt_flip_qualifier bench
// Drives accelerometer ticks through the qualifier under several register
// settings and checks every orientation/redraw result against an in-bench
// predictor that tracks the history ring, its priming and the orientation.
// ----------------------------------------------------------------------------

// Predicts one verdict per accepted tick and checks the block's verdicts in order.
class tilt_scoreboard;
  typedef struct packed {
    logic orient;
    logic redraw;
  } verdict_t;

  bit          manual;
  int          tilt_lim;
  int          flip_lvl;
  bit          marks_ring[tfq_pkg::HISTORY_DEPTH];
  int          wpos;
  bit          primed;
  bit          dir;
  verdict_t    due_verdicts[$];
  int          failures;

  function new();
    manual   = 1'b0;
    tilt_lim = int'(tfq_pkg::TILT_LIMIT_RST);
    flip_lvl = int'(tfq_pkg::FLIP_LEVEL_RST);
    foreach (marks_ring[i]) marks_ring[i] = 1'b0;
    wpos     = 0;
    primed   = 1'b0;
    dir      = 1'b0;
    failures = 0;
  endfunction

  function void set_reg(logic [tfq_pkg::CFG_IDX_W-1:0] idx, logic [tfq_pkg::CFG_W-1:0] val);
    case (idx)
      tfq_pkg::REG_MANUAL_ORIENT: manual   = val[0];
      tfq_pkg::REG_TILT_LIMIT:    tilt_lim = int'(val);
      tfq_pkg::REG_FLIP_LEVEL:    flip_lvl = int'(val);
      default: ;
    endcase
  endfunction

  function void predict_tick(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z);
    int       ax;
    int       az;
    int       idx;
    int       nx;
    int       marks;
    int       trans;
    bit       mark;
    verdict_t v;
    v.redraw = 1'b0;
    if (!manual) begin
      ax = (x < 0) ? -int'(x) : int'(x);
      az = (z < 0) ? -int'(z) : int'(z);
      if (ax > tilt_lim || az > tilt_lim) mark = 1'b0;
      else if (!dir) mark = int'(y) > flip_lvl;
      else mark = int'(y) < -flip_lvl;
      // prime the whole ring on the first tick, else write one slot
      if (!primed) begin
        foreach (marks_ring[i]) marks_ring[i] = mark;
        wpos   = 0;
        primed = 1'b1;
      end else begin
        marks_ring[wpos] = mark;
        wpos = (wpos + 1 == tfq_pkg::HISTORY_DEPTH) ? 0 : wpos + 1;
      end
      // walk from the oldest slot over depth-1 steps
      marks = 0;
      trans = 0;
      idx   = wpos;
      for (int i = 0; i + 1 < tfq_pkg::HISTORY_DEPTH; i++) begin
        nx = (idx + 1 == tfq_pkg::HISTORY_DEPTH) ? 0 : idx + 1;
        if (marks_ring[idx]) marks++;
        if (marks_ring[nx] != marks_ring[idx]) trans++;
        idx = nx;
      end
      if (marks > tfq_pkg::HISTORY_DEPTH / 2 && trans < marks / 2) begin
        dir = ~dir;
        foreach (marks_ring[i]) marks_ring[i] = 1'b0;
        v.redraw = 1'b1;
      end
    end
    v.orient = dir;
    due_verdicts.push_back(v);
  endfunction

  function void check_verdict(logic orient, logic redraw);
    verdict_t v;
    if (due_verdicts.size() == 0) begin
      $display("%0t: unexpected result orientation=%b redraw=%b", $time, orient, redraw);
      failures++;
    end else begin
      v = due_verdicts.pop_front();
      if (orient !== v.orient) begin
        $display("%0t: orientation expected %b actual %b", $time, v.orient, orient);
        failures++;
      end
      if (redraw !== v.redraw) begin
        $display("%0t: redraw_request expected %b actual %b", $time, v.redraw, redraw);
        failures++;
      end
    end
  endfunction

  function int pending();
    return due_verdicts.size();
  endfunction
endclass

module tb;
  import tfq_pkg::*;

  // unused register slot; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam int RESET_CYCLES = 6;
  localparam int SETTLE       = HISTORY_DEPTH + 12;
  localparam int STALL_LIMIT  = 3000;
  localparam int IDLE_PCT     = 31;
  localparam int CALM_FIRST   = 900;
  localparam int CALM_LAST    = 1200;
  localparam int PRESSURE_AT  = 150;
  localparam int HOLD_CYCLES  = 400;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = REG_MANUAL_ORIENT;
  logic [CFG_W-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [ACC_W-1:0] in_accel_x = '0;
  logic signed [ACC_W-1:0] in_accel_y = '0;
  logic signed [ACC_W-1:0] in_accel_z = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    out_orientation;
  logic                    out_redraw_request;

  tilt_scoreboard sb = new();

  int ticks_sent   = 0;
  int results_seen = 0;
  int hold_left    = 0;
  bit pressure_done = 1'b0;
  int stall_cycles = 0;

  tilt_flip_qualifier uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_accel_x        (in_accel_x),
    .in_accel_y        (in_accel_y),
    .in_accel_z        (in_accel_z),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_orientation   (out_orientation),
    .out_redraw_request(out_redraw_request)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side: check each transfer, then pick out_ready for the next cycle.
  // Once, hold off for a long stretch so the block backs up into its input.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_verdict(out_orientation, out_redraw_request);
      results_seen <= results_seen + 1;
    end
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!pressure_done && results_seen == PRESSURE_AT) begin
      pressure_done <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      out_ready     <= 1'b0;
    end else if (results_seen >= CALM_FIRST && results_seen < CALM_LAST) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog: count cycles without any transfer on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one tick, idling at random first, and hold it until the transfer.
  task automatic send_tick(logic signed [ACC_W-1:0] x, logic signed [ACC_W-1:0] y,
                           logic signed [ACC_W-1:0] z);
    while (!(ticks_sent >= CALM_FIRST && ticks_sent < CALM_LAST) &&
           $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_accel_x <= x;
    in_accel_y <= y;
    in_accel_z <= z;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    sb.predict_tick(x, y, z);
    ticks_sent++;
  endtask

  // Drop valid, wait for every outstanding verdict, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // Write all three registers; the upper bits of the manual word are junk.
  task automatic program_regs(bit manual, int tilt, int flip);
    write_reg(REG_MANUAL_ORIENT, {(CFG_W-1)'($urandom), manual});
    write_reg(REG_TILT_LIMIT, CFG_W'(tilt));
    write_reg(REG_FLIP_LEVEL, CFG_W'(flip));
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Build a sample that passes the tilt window and the flip test for one side (no up sample can pass at flip 32767).
  function automatic void upside_sample(bit down, int tilt, int flip,
                                        output logic signed [ACC_W-1:0] x,
                                        output logic signed [ACC_W-1:0] y,
                                        output logic signed [ACC_W-1:0] z);
    x = ACC_W'(int'($urandom_range(0, 2 * tilt)) - tilt);
    z = ACC_W'(int'($urandom_range(0, 2 * tilt)) - tilt);
    if (down) begin
      y = ACC_W'(-(flip + 1) - int'($urandom_range(0, 32767 - flip)));
    end else if (flip == 32767) begin
      y = ACC_W'($urandom);
    end else begin
      y = ACC_W'(flip + 1 + int'($urandom_range(0, 32766 - flip)));
    end
  endfunction

  // Mostly steady runs of one side with some noise; the rest is pure noise.
  task automatic stream_ticks(int count);
    int                      left;
    int                      run_len;
    bit                      down;
    logic signed [ACC_W-1:0] x;
    logic signed [ACC_W-1:0] y;
    logic signed [ACC_W-1:0] z;
    left = count;
    while (left > 0) begin
      if ($urandom_range(0, 99) < 70) begin
        run_len = $urandom_range(8, 40);
        down    = $urandom_range(0, 1);
        for (int k = 0; k < run_len && left > 0; k++) begin
          if ($urandom_range(0, 99) < 90) begin
            upside_sample(down, sb.tilt_lim, sb.flip_lvl, x, y, z);
          end else begin
            x = ACC_W'($urandom);
            y = ACC_W'($urandom);
            z = ACC_W'($urandom);
          end
          send_tick(x, y, z);
          left--;
        end
      end else begin
        send_tick(ACC_W'($urandom), ACC_W'($urandom), ACC_W'($urandom));
        left--;
      end
    end
  endtask

  task automatic run_phase(bit manual, int tilt, int flip, int count);
    program_regs(manual, tilt, flip);
    stream_ticks(count);
    drain();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: tilt 819, flip 3277, orientation up, ring unprimed.
    // First tick is marked, so priming fills the ring and it flips at once.
    send_tick(16'sd0, 16'sd4096, 16'sd0);
    // now facing down: the test looks for y below -flip
    send_tick(16'sd819, -16'sd3278, -16'sd819);
    send_tick(16'sd820, -16'sd4096, 16'sd0);
    send_tick(16'sd0, -16'sd3277, 16'sd0);
    send_tick(-16'sd32768, -16'sd32768, 16'sd0);
    send_tick(16'sd0, -16'sd32768, -16'sd32768);
    send_tick(16'sd32767, 16'sd32767, 16'sd32767);
    send_tick(-16'sd819, -16'sd3278, 16'sd819);
    send_tick(16'sd0, -16'sd3278, -16'sd820);
    // steady down run to qualify the flip back to up
    repeat (16) send_tick(16'sd0, -16'sd4096, 16'sd0);
    send_tick(16'sd0, 16'sd3278, 16'sd0);
    send_tick(16'sd0, 16'sd3277, 16'sd0);
    drain();

    // Manual mode: ticks change nothing and never request a redraw.
    program_regs(1'b1, 819, 3277);
    send_tick(16'sd0, 16'sd32767, 16'sd0);
    send_tick(16'sd0, -16'sd32768, 16'sd0);
    drain();

    run_phase(1'b0, 819, 3277, 250);
    run_phase(1'b0, 0, 0, 200);
    run_phase(1'b0, 32767, 32767, 200);
    // index past the register list; must have no effect
    write_reg(REG_UNUSED, CFG_W'($urandom));
    run_phase(1'b1, $urandom_range(0, 32767), $urandom_range(0, 32767), 100);
    run_phase(1'b0, $urandom_range(0, 32767), $urandom_range(0, 32767), 250);
    run_phase(1'b0, 32767, 0, 200);
    run_phase(1'b0, 0, 32767, 150);
    run_phase(1'b0, $urandom_range(200, 3000), $urandom_range(1000, 8000), 470);

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
